### sv/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lru_pkg;

    localparam int PAGE_BITS      = 8;
    localparam int FRAME_COUNT_W  = 5;
    localparam int IDX_W          = 6;
    localparam int FRAME_OUT_W    = 4;
    localparam int FAULT_W        = 16;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 5'd3;
    localparam logic [FAULT_W-1:0]       FAULT_MAX         = 16'hFFFF;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page_number;
        logic                 last_request;
    } lru_req_t;

    typedef struct packed {
        logic                   page_fault;
        logic [FRAME_OUT_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_BITS-1:0]   evicted_page;
        logic [FAULT_W-1:0]     fault_total;
        logic                   sequence_end;
    } lru_rsp_t;

    // Running search result handed from cell to cell.
    typedef struct packed {
        logic                 valid;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [IDX_W-1:0]     hit_rank;
        logic                 found;
        logic [IDX_W-1:0]     old_idx;
        logic [IDX_W-1:0]     old_rank;
        logic [PAGE_BITS-1:0] old_page;
    } lru_scan_t;

    // Update command broadcast to every cell once the search is done.
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [IDX_W-1:0] frame;
        logic             fill;
        logic             age_all;
        logic [IDX_W-1:0] limit;
    } lru_upd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } lru_state_t;

endpackage

### sv/lru_page_replacement.sv
// Top level: a row of frame cells searched by a token that moves one frame per cycle.
// The result strobe is registered once the search token leaves frame cell N-1, where N is
// frame_count clamped to 1..MAX_FRAMES; the search token visits one frame cell per cycle.
// One item is taken at a time: busy stays high until the result strobe, and the
// next item can be accepted at the edge that ends the strobe.
// Reset clears all frames, ranks and counts and sets frame_count to 3; the receiver
// cannot stall, so each result is shown for exactly one cycle.
module lru_page_replacement #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  lru_pkg::lru_req_t                     request,
    output logic                                  busy,
    output logic                                  result_valid,
    output lru_pkg::lru_rsp_t                     result,
    input  logic                                  cfg_we,
    input  logic [lru_pkg::FRAME_COUNT_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [lru_pkg::FRAME_COUNT_W-1:0] frame_count_reg;
    logic [CW-1:0]                     used;
    logic [CW-1:0]                     used_m1;
    logic [MAX_FRAMES-1:0]             active;
    logic                              launch;
    logic [lru_pkg::PAGE_BITS-1:0]     page;
    lru_pkg::lru_scan_t                scan_first;
    lru_pkg::lru_scan_t                scan_out [MAX_FRAMES];
    lru_pkg::lru_scan_t                scan_done;
    lru_pkg::lru_upd_t                 upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lru_pkg::FRAME_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            frame_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            used = CW'(1);
        end
        else if (32'(frame_count_reg) > 32'(MAX_FRAMES))
        begin
            used = CW'(MAX_FRAMES);
        end
        else
        begin
            used = CW'(frame_count_reg);
        end
    end

    assign used_m1   = used - CW'(1);
    assign scan_done = scan_out[IW'(used_m1)];

    always_comb
    begin
        scan_first       = '0;
        scan_first.valid = launch;
    end

    for (genvar k = 0; k < MAX_FRAMES; k++)
    begin : g_cell
        assign active[k] = (CW'(k) < used);
        if (k == 0)
        begin : g_head
            lru_cell #(
                .MAX_FRAMES (MAX_FRAMES),
                .CELL_IDX   (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active[k]),
                .page     (page),
                .scan_in  (scan_first),
                .scan_out (scan_out[k]),
                .upd      (upd)
            );
        end
        else
        begin : g_body
            lru_cell #(
                .MAX_FRAMES (MAX_FRAMES),
                .CELL_IDX   (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .active   (active[k]),
                .page     (page),
                .scan_in  (scan_out[k-1]),
                .scan_out (scan_out[k]),
                .upd      (upd)
            );
        end
    end

    lru_ctrl #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_in       (request),
        .busy         (busy),
        .used         (used),
        .launch       (launch),
        .page         (page),
        .scan_done    (scan_done),
        .upd          (upd),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### sv/lru_cell.sv
// One frame cell: holds a page, its valid bit and rank, and joins the search chain.
module lru_cell #(
    parameter int MAX_FRAMES = 16,
    parameter int CELL_IDX   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          active,
    input  logic [lru_pkg::PAGE_BITS-1:0] page,
    input  lru_pkg::lru_scan_t            scan_in,
    output lru_pkg::lru_scan_t            scan_out,
    input  lru_pkg::lru_upd_t             upd
);

    localparam int RW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [lru_pkg::PAGE_BITS-1:0] page_reg;
    logic                          valid_reg;
    logic                          valid_next;
    logic [RW-1:0]                 rank_reg;
    logic [RW-1:0]                 rank_next;
    lru_pkg::lru_scan_t            scan_reg;
    lru_pkg::lru_scan_t            scan_next;
    logic [lru_pkg::IDX_W-1:0]     rank_ext;
    logic                          is_target;

    assign rank_ext  = lru_pkg::IDX_W'(rank_reg);
    assign is_target = (lru_pkg::IDX_W'(CELL_IDX) == upd.frame);
    assign scan_out  = scan_reg;

    always_comb
    begin
        scan_next       = scan_in;
        scan_next.valid = scan_in.valid && active;
        if (scan_in.valid && active)
        begin
            if (valid_reg && !scan_in.hit && (page_reg == page))
            begin
                scan_next.hit      = 1'b1;
                scan_next.hit_idx  = lru_pkg::IDX_W'(CELL_IDX);
                scan_next.hit_rank = rank_ext;
            end
            // Strictly greater keeps the lowest index among equally old frames.
            if (valid_reg && (!scan_in.found || (rank_ext > scan_in.old_rank)))
            begin
                scan_next.found    = 1'b1;
                scan_next.old_idx  = lru_pkg::IDX_W'(CELL_IDX);
                scan_next.old_rank = rank_ext;
                scan_next.old_page = page_reg;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (upd.en)
        begin
            if (is_target)
            begin
                rank_next = '0;
                if (upd.fill)
                begin
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg && (upd.age_all || (rank_ext < upd.limit)) &&
                     (rank_reg != RW'(MAX_FRAMES - 1)))
            begin
                rank_next = rank_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en && upd.fill && is_target)
        begin
            page_reg <= page;
        end
    end

endmodule

### sv/lru_ctrl.sv
// Sequencer: takes an item, launches the search, decides the frame and reports the result.
module lru_ctrl #(
    parameter int MAX_FRAMES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  lru_pkg::lru_req_t             req_in,
    output logic                          busy,
    input  logic [$clog2(MAX_FRAMES+1)-1:0] used,
    output logic                          launch,
    output logic [lru_pkg::PAGE_BITS-1:0] page,
    input  lru_pkg::lru_scan_t            scan_done,
    output lru_pkg::lru_upd_t             upd,
    output logic                          result_valid,
    output lru_pkg::lru_rsp_t             result
);

    localparam int CW = $clog2(MAX_FRAMES + 1);

    lru_pkg::lru_state_t        state_reg;
    lru_pkg::lru_state_t        state_next;
    lru_pkg::lru_req_t          req_reg;
    logic                       launch_reg;
    logic [CW-1:0]              filled_reg;
    logic [CW-1:0]              filled_next;
    logic [lru_pkg::FAULT_W-1:0] fault_reg;
    logic [lru_pkg::FAULT_W-1:0] fault_next;
    logic [lru_pkg::FAULT_W-1:0] fault_shown;
    logic                       result_valid_reg;
    lru_pkg::lru_rsp_t          result_reg;
    lru_pkg::lru_rsp_t          rsp_next;
    logic                       accept;
    logic                       done;

    assign accept       = start && (state_reg == lru_pkg::ST_IDLE);
    assign done         = (state_reg == lru_pkg::ST_SCAN) && scan_done.valid;
    assign launch       = launch_reg;
    assign page         = req_reg.page_number;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN:
            begin
                if (done)
                begin
                    state_next = lru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != lru_pkg::ST_IDLE);
    end

    // Replacement decision once the search token has left the last frame in use.
    always_comb
    begin
        upd         = '0;
        rsp_next    = '0;
        filled_next = filled_reg;
        fault_shown = fault_reg;
        upd.en      = done;
        if (scan_done.hit)
        begin
            upd.frame = scan_done.hit_idx;
            upd.limit = scan_done.hit_rank;
        end
        else
        begin
            upd.fill = 1'b1;
            if (filled_reg < used)
            begin
                upd.frame   = lru_pkg::IDX_W'(filled_reg);
                upd.age_all = 1'b1;
                filled_next = filled_reg + CW'(1);
            end
            else if (scan_done.found)
            begin
                upd.frame             = scan_done.old_idx;
                upd.limit             = scan_done.old_rank;
                rsp_next.evicted_valid = 1'b1;
                rsp_next.evicted_page  = scan_done.old_page;
            end
            else
            begin
                upd.frame   = '0;
                upd.age_all = 1'b1;
            end
            if (fault_reg != lru_pkg::FAULT_MAX)
            begin
                fault_shown = fault_reg + lru_pkg::FAULT_W'(1);
            end
        end
        rsp_next.page_fault   = !scan_done.hit;
        rsp_next.frame_index  = lru_pkg::FRAME_OUT_W'(upd.frame);
        rsp_next.fault_total  = fault_shown;
        rsp_next.sequence_end = req_reg.last_request;
        fault_next            = fault_shown;
        upd.clear             = done && req_reg.last_request;
        if (!done)
        begin
            filled_next = filled_reg;
            fault_next  = fault_reg;
        end
        else if (req_reg.last_request)
        begin
            filled_next = '0;
            fault_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lru_pkg::ST_IDLE;
            launch_reg       <= 1'b0;
            filled_reg       <= '0;
            fault_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            launch_reg       <= accept;
            filled_reg       <= filled_next;
            fault_reg        <= fault_next;
            result_valid_reg <= done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_in;
        end
        if (done)
        begin
            result_reg <= rsp_next;
        end
    end

endmodule
